// ===== src/degree_biased_random_pick_macros.svh =====
// assertion helpers used by the checker file
`ifndef DEGREE_BIASED_RANDOM_PICK_MACROS_SVH
`define DEGREE_BIASED_RANDOM_PICK_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define DBRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define DBRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dbrp_pkg.sv =====
package dbrp_pkg;

  localparam int VID_W = 32;
  localparam int DEG_W = 16;
  localparam int IDX_W = 10;
  localparam int TOT_W = 11;

  // total weight saturates here
  localparam logic [TOT_W-1:0] TOT_SAT = 11'd2047;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_CHECK,
    ST_SEARCH,
    ST_SCAN,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic sum_step;
    logic search_init;
    logic search_step;
    logic scan_step;
    logic set_err;
    logic clear;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic is_draw;
    logic g_last;
    logic draw_bad;
    logic search_hit;
    logic scan_hit;
    logic scan_end;
  } status_t;

endpackage

// ===== src/degree_biased_random_pick.sv =====
// degree-biased weighted random pick of a vertex
//
// input channel (in_valid_i / in_ready_o): one beat is a load (command 0,
// vertex_id_i and degree_i) or a draw (command 1, random_index_i).
// output channel (out_valid_o / out_ready_i): one beat per input beat with
// chosen_vertex_o, total_weight_o (saturating at 2047) and error_o.
// a candidate whose degree trails the largest stored degree by g < LEVELS
// weighs 2^(LEVELS-1-g); a draw walks gaps in order, then arrival order, and
// returns the first candidate whose running weight exceeds the index, then
// empties the store.
// one item at a time: a load steps through capture, histogram update, one gap
// bucket per cycle for the total and the result register; a draw adds a check,
// a search over the gaps, a scan of the candidate memory, one entry per cycle
// through its single read port, and the clearing of the store before its result.
// reset empties the store and drops any pending result.
// a stalled receiver holds the finished beat in the output register; the
// next input beat is still taken and worked on, and waits only to hand off.
module degree_biased_random_pick import dbrp_pkg::*; #(
  parameter int MAX_CANDIDATES = 64,
  parameter int LEVELS         = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [VID_W-1:0] vertex_id_i,
  input  logic [DEG_W-1:0] degree_i,
  input  logic [IDX_W-1:0] random_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VID_W-1:0] chosen_vertex_o,
  output logic [TOT_W-1:0] total_weight_o,
  output logic             error_o
);

  // commands down to the datapath, flags back up
  ctrl_t   ctrl;
  status_t status;

  // sequencer: capture, update, sum, check, search, scan, clear, finish
  dbrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // candidate memory, gap histogram, total and pick logic, result register
  dbrp_datapath #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .LEVELS         (LEVELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .command_i       (command_i),
    .vertex_id_i     (vertex_id_i),
    .degree_i        (degree_i),
    .random_index_i  (random_index_i),
    .chosen_vertex_o (chosen_vertex_o),
    .total_weight_o  (total_weight_o),
    .error_o         (error_o)
  );

endmodule

// ===== src/dbrp_ctrl.sv =====
module dbrp_ctrl import dbrp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ctrl_o.update = 1'b1;
        state_d       = ST_SUM;
      end
      ST_SUM: begin
        ctrl_o.sum_step = 1'b1;
        if (status_i.g_last) begin
          state_d = status_i.is_draw ? ST_CHECK : ST_FINISH;
        end
      end
      ST_CHECK: begin
        if (status_i.draw_bad) begin
          ctrl_o.set_err = 1'b1;
          state_d        = ST_CLEAR;
        end else begin
          ctrl_o.search_init = 1'b1;
          state_d            = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        ctrl_o.search_step = 1'b1;
        if (status_i.search_hit) begin
          state_d = ST_SCAN;
        end else if (status_i.g_last) begin
          ctrl_o.set_err = 1'b1;
          state_d        = ST_CLEAR;
        end
      end
      ST_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        if (status_i.scan_hit) begin
          state_d = ST_CLEAR;
        end else if (status_i.scan_end) begin
          ctrl_o.set_err = 1'b1;
          state_d        = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        ctrl_o.clear = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/dbrp_datapath.sv =====
module dbrp_datapath import dbrp_pkg::*; #(
  parameter int MAX_CANDIDATES = 64,
  parameter int LEVELS         = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  output status_t          status_o,
  input  logic             command_i,
  input  logic [VID_W-1:0] vertex_id_i,
  input  logic [DEG_W-1:0] degree_i,
  input  logic [IDX_W-1:0] random_index_i,
  output logic [VID_W-1:0] chosen_vertex_o,
  output logic [TOT_W-1:0] total_weight_o,
  output logic             error_o
);

  localparam int CNTW = $clog2(MAX_CANDIDATES + 1);
  localparam int AW   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int GW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int BKW  = CNTW + LEVELS - 1;
  localparam int SW   = ((BKW > TOT_W) ? BKW : TOT_W) + 1;
  localparam int MEMW = VID_W + DEG_W;

  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_CANDIDATES);
  localparam logic [GW-1:0]   G_LAST  = GW'(LEVELS - 1);

  // captured item
  logic             cmd_q;
  logic [VID_W-1:0] vid_q;
  logic [DEG_W-1:0] deg_q;
  logic [IDX_W-1:0] idx_q;

  // store bookkeeping
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [DEG_W-1:0] max_q, max_d;
  logic [CNTW-1:0]  hist_q [LEVELS];
  logic [CNTW-1:0]  hist_d [LEVELS];

  // candidate store, vertex above degree
  logic [MEMW-1:0]  mem [MAX_CANDIDATES];
  logic [MEMW-1:0]  rd_q;
  logic             rd_vld_q;

  // per-item work registers
  logic [TOT_W-1:0] acc_q;
  logic [GW-1:0]    g_q;
  logic [TOT_W-1:0] cum_q;
  logic [GW-1:0]    sel_g_q;
  logic [CNTW-1:0]  k_q;
  logic [CNTW-1:0]  a_q;
  logic [CNTW-1:0]  hits_q;
  logic [VID_W-1:0] chosen_q;
  logic             err_q;

  logic [VID_W-1:0] out_chosen_q;
  logic [TOT_W-1:0] out_total_q;
  logic             out_err_q;

  logic             full;
  logic             load_ok;
  logic             mem_we;
  logic [DEG_W-1:0] up_d;
  logic [DEG_W-1:0] gap;
  logic [GW-1:0]    shamt;
  logic [BKW-1:0]   bucket;
  logic [SW-1:0]    acc_sum;
  logic [TOT_W-1:0] acc_sat;
  logic [TOT_W-1:0] rem;
  logic             search_hit;
  logic [TOT_W-1:0] rank;
  logic [DEG_W-1:0] rd_deg;
  logic [VID_W-1:0] rd_vid;
  logic             match;
  logic             scan_hit;
  logic             a_more;

  assign full    = (cnt_q == MAX_CNT);
  assign load_ok = ctrl_i.update && (cmd_q == CMD_LOAD) && !full;
  assign mem_we  = load_ok;
  assign up_d    = deg_q - max_q;
  assign gap     = max_q - deg_q;

  // weight of one gap bucket: count times 2^(LEVELS-1-g)
  assign shamt   = G_LAST - g_q;
  assign bucket  = BKW'(hist_q[g_q]) << shamt;
  assign acc_sum = SW'(acc_q) + SW'(bucket);
  assign acc_sat = (acc_sum > SW'(TOT_SAT)) ? TOT_SAT : TOT_W'(acc_sum);

  assign rem        = {1'b0, idx_q} - cum_q;
  assign search_hit = (SW'(rem) < SW'(bucket));
  assign rank       = rem >> shamt;

  assign rd_deg   = rd_q[DEG_W-1:0];
  assign rd_vid   = rd_q[MEMW-1:DEG_W];
  assign match    = rd_vld_q && (rd_deg <= max_q) && ((max_q - rd_deg) == DEG_W'(sel_g_q));
  assign scan_hit = match && (hits_q == k_q);
  assign a_more   = (a_q < cnt_q);

  always_comb begin
    status_o            = '0;
    status_o.is_draw    = (cmd_q == CMD_DRAW);
    status_o.g_last     = (g_q == G_LAST);
    status_o.draw_bad   = (cnt_q == '0) || ({1'b0, idx_q} >= acc_q);
    status_o.search_hit = search_hit;
    status_o.scan_hit   = scan_hit;
    status_o.scan_end   = !rd_vld_q && !a_more;
  end

  // gap histogram: a new maximum shifts every bucket up by the rise
  always_comb begin
    hist_d = hist_q;
    cnt_d  = cnt_q;
    max_d  = max_q;
    if (ctrl_i.clear) begin
      for (int g = 0; g < LEVELS; g++) begin
        hist_d[g] = '0;
      end
      cnt_d = '0;
      max_d = '0;
    end else if (load_ok) begin
      cnt_d = cnt_q + CNTW'(1);
      if (deg_q > max_q) begin
        max_d = deg_q;
        for (int g = 0; g < LEVELS; g++) begin
          if (up_d <= DEG_W'(g)) begin
            hist_d[g] = hist_q[GW'(g) - GW'(up_d)];
          end else begin
            hist_d[g] = '0;
          end
        end
        hist_d[0] = CNTW'(1);
      end else begin
        for (int g = 0; g < LEVELS; g++) begin
          if (gap == DEG_W'(g)) begin
            hist_d[g] = hist_q[g] + CNTW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      max_q    <= '0;
      rd_vld_q <= 1'b0;
      for (int g = 0; g < LEVELS; g++) begin
        hist_q[g] <= '0;
      end
    end else begin
      cnt_q    <= cnt_d;
      max_q    <= max_d;
      rd_vld_q <= ctrl_i.scan_step && a_more;
      hist_q   <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= {vid_q, deg_q};
    end
    rd_q <= mem[a_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q    <= command_i;
      vid_q    <= vertex_id_i;
      deg_q    <= degree_i;
      idx_q    <= random_index_i;
      chosen_q <= '0;
      err_q    <= 1'b0;
    end
    if (ctrl_i.update) begin
      acc_q <= '0;
      g_q   <= '0;
      if ((cmd_q == CMD_LOAD) && full) begin
        err_q <= 1'b1;
      end
    end
    if (ctrl_i.sum_step) begin
      acc_q <= acc_sat;
      if (g_q != G_LAST) begin
        g_q <= g_q + GW'(1);
      end
    end
    if (ctrl_i.search_init) begin
      g_q    <= '0;
      cum_q  <= '0;
      a_q    <= '0;
      hits_q <= '0;
    end
    if (ctrl_i.search_step) begin
      if (search_hit) begin
        sel_g_q <= g_q;
        k_q     <= CNTW'(rank);
      end else begin
        cum_q <= cum_q + TOT_W'(bucket);
        if (g_q != G_LAST) begin
          g_q <= g_q + GW'(1);
        end
      end
    end
    if (ctrl_i.scan_step) begin
      if (a_more) begin
        a_q <= a_q + CNTW'(1);
      end
      if (scan_hit) begin
        chosen_q <= rd_vid;
      end else if (match) begin
        hits_q <= hits_q + CNTW'(1);
      end
    end
    if (ctrl_i.set_err) begin
      err_q <= 1'b1;
    end
    if (ctrl_i.out_load) begin
      out_chosen_q <= chosen_q;
      out_total_q  <= acc_q;
      out_err_q    <= err_q;
    end
  end

  assign chosen_vertex_o = out_chosen_q;
  assign total_weight_o  = out_total_q;
  assign error_o         = out_err_q;

endmodule

// ===== src/dbrp_checker.sv =====
`include "degree_biased_random_pick_macros.svh"

module dbrp_checker import dbrp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             command_i,
  input logic [VID_W-1:0] vertex_id_i,
  input logic [DEG_W-1:0] degree_i,
  input logic [IDX_W-1:0] random_index_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [VID_W-1:0] chosen_vertex_o,
  input logic [TOT_W-1:0] total_weight_o,
  input logic             error_o
);

  // stalled result beat holds
  `DBRP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(chosen_vertex_o) && $stable(total_weight_o) && $stable(error_o), "result changed while stalled")

  // one item in flight: no accept right after an accept
  `DBRP_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

  // an error beat carries no vertex
  `DBRP_ASSERT_SAME(a_err_zero, out_valid_o && error_o, chosen_vertex_o == '0, "vertex on error beat")

  // a clean beat always sees a nonzero total
  `DBRP_ASSERT_SAME(a_total_pos, out_valid_o && !error_o, total_weight_o != '0, "zero total on clean beat")

endmodule

bind degree_biased_random_pick dbrp_checker u_dbrp_checker (.*);

// ===== verif/tb_degree_biased_random_pick.sv =====
`timescale 1ns / 1ps

module tb_degree_biased_random_pick;
  import dbrp_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int GAP_LEVELS   = 5;
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_PAUSE    = 13;
  localparam int TARGET_BEATS = 950;
  // must outlast a full-store draw, whose scan can walk the whole store
  localparam int DRAIN_CYCLES = 120;
  // longest quiet stretch in a good run is a full draw plus both pauses
  localparam int STALL_LIMIT  = 4000;

  // what one output beat should carry
  typedef struct packed {
    logic [VID_W-1:0] vertex;
    logic [TOT_W-1:0] total;
    logic             err;
  } pick_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             command_i;
  logic [VID_W-1:0] vertex_id_i;
  logic [DEG_W-1:0] degree_i;
  logic [IDX_W-1:0] random_index_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [VID_W-1:0] chosen_vertex_o;
  logic [TOT_W-1:0] total_weight_o;
  logic             error_o;

  degree_biased_random_pick #(
    .MAX_CANDIDATES(STORE_DEPTH),
    .LEVELS        (GAP_LEVELS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .vertex_id_i    (vertex_id_i),
    .degree_i       (degree_i),
    .random_index_i (random_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chosen_vertex_o(chosen_vertex_o),
    .total_weight_o (total_weight_o),
    .error_o        (error_o)
  );

  // shadow copy of the candidate store
  logic [VID_W-1:0] shadow_vertex [STORE_DEPTH];
  logic [DEG_W-1:0] shadow_degree [STORE_DEPTH];
  int unsigned      shadow_count = 0;
  logic [DEG_W-1:0] shadow_top_degree = '0;

  // predicted output beats, oldest first
  pick_result_t pending_picks[$];

  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned idle_cycles = 0;
  // while set, that side runs back to back with no pauses
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // sum of weights over the shadow store, unsaturated
  function automatic int unsigned stored_weight();
    int unsigned sum;
    int unsigned gap;
    sum = 0;
    for (int i = 0; i < shadow_count; i++) begin
      // every stored degree is at most the top one, but guard anyway
      if (shadow_degree[i] <= shadow_top_degree) begin
        gap = 32'(shadow_top_degree - shadow_degree[i]);
        if (gap < GAP_LEVELS) sum += 1 << (GAP_LEVELS - 1 - gap);
      end
    end
    return sum;
  endfunction

  // advances the shadow store by one input beat and returns its output beat
  function automatic pick_result_t predict_pick(logic cmd, logic [VID_W-1:0] vid,
                                                logic [DEG_W-1:0] deg,
                                                logic [IDX_W-1:0] idx);
    pick_result_t res;
    int unsigned  sum;
    int unsigned  running;
    bit           found;
    res     = '0;
    found   = 1'b0;
    running = 0;
    if (cmd == CMD_LOAD) begin
      // a load into a full store is dropped and flagged
      if (shadow_count >= STORE_DEPTH) begin
        res.err = 1'b1;
      end else begin
        shadow_vertex[shadow_count] = vid;
        shadow_degree[shadow_count] = deg;
        shadow_count++;
        if (deg > shadow_top_degree) shadow_top_degree = deg;
      end
      sum = stored_weight();
    end else begin
      // total is reported as it stood before the clear
      sum = stored_weight();
      if (shadow_count == 0 || idx >= sum) begin
        res.err = 1'b1;
      end else begin
        // smallest gap first, arrival order inside one gap
        for (int g = 0; g < GAP_LEVELS && !found; g++) begin
          for (int i = 0; i < shadow_count && !found; i++) begin
            if (shadow_degree[i] <= shadow_top_degree &&
                shadow_top_degree - shadow_degree[i] == g) begin
              running += 1 << (GAP_LEVELS - 1 - g);
              if (running > idx) begin
                res.vertex = shadow_vertex[i];
                found      = 1'b1;
              end
            end
          end
        end
        if (!found) res.err = 1'b1;
      end
      // every draw empties the store, flagged or not
      shadow_count      = 0;
      shadow_top_degree = '0;
    end
    res.total = (sum > TOT_SAT) ? TOT_SAT : sum[TOT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // drives one input beat after a random pause and books its prediction
  task automatic send_beat(logic cmd, logic [VID_W-1:0] vid, logic [DEG_W-1:0] deg,
                           logic [IDX_W-1:0] idx);
    int unsigned  pause;
    pick_result_t booked;
    if ($urandom_range(0, 47) == 0) send_burst = !send_burst;
    pause = send_burst ? 0 : $urandom_range(0, MAX_PAUSE);
    if (pause > 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    vertex_id_i    <= vid;
    degree_i       <= deg;
    random_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    booked        = predict_pick(cmd, vid, deg, idx);
    pending_picks = {pending_picks, booked};
    beats_sent++;
  endtask

  // unused fields of a beat still carry random bits
  task automatic load_candidate(logic [VID_W-1:0] vid, logic [DEG_W-1:0] deg);
    send_beat(CMD_LOAD, vid, deg, IDX_W'($urandom_range(0, 1023)));
  endtask

  task automatic draw_pick(logic [IDX_W-1:0] idx);
    send_beat(CMD_DRAW, $urandom, DEG_W'($urandom_range(0, 65535)), idx);
  endtask

  task automatic test_empty_draw();
    draw_pick(10'd0);
    draw_pick(10'h3FF);
  endtask

  task automatic test_degree_extremes();
    load_candidate(32'h0000_0000, 16'h0000);
    // top degree jumps, the first entry drops to weight zero
    load_candidate(32'hFFFF_FFFF, 16'hFFFF);
    // deepest gap that still weighs one
    load_candidate(32'h1234_5678, 16'hFFFB);
    // same vertex again is a separate entry
    load_candidate(32'hFFFF_FFFF, 16'hFFFE);
    // total 25: walks past both top entries onto the deepest gap
    draw_pick(10'd24);
  endtask

  task automatic test_index_bounds();
    repeat (3) load_candidate($urandom, 16'd100);
    // index equal to the total is out of range
    draw_pick(10'd48);
    load_candidate(32'hA5A5_5A5A, 16'd7);
    draw_pick(10'd0);
    load_candidate(32'h0000_0001, 16'd9);
    load_candidate(32'h8000_0000, 16'd7);
    // last unit of the total lands on the gap-two entry
    draw_pick(10'd19);
    load_candidate(32'h0000_0002, 16'd3);
    draw_pick(10'h3FF);
  endtask

  task automatic test_full_store();
    logic [DEG_W-1:0] deg;
    int unsigned      total;
    deg = DEG_W'($urandom_range(0, 65535));
    repeat (STORE_DEPTH) load_candidate($urandom, deg);
    // refused beat must not move the top degree either
    load_candidate($urandom, ~deg);
    // total is 1024 here, so the top index picks the last entry
    draw_pick(10'h3FF);
    deg = DEG_W'($urandom_range(GAP_LEVELS, 65535));
    repeat (STORE_DEPTH + 2)
      load_candidate($urandom, deg - DEG_W'($urandom_range(0, GAP_LEVELS)));
    total = stored_weight();
    draw_pick(IDX_W'($urandom_range(0, total - 1)));
  endtask

  // runs of loads clustered near one degree, closed by a draw
  task automatic test_random_sequences();
    int unsigned      n;
    int unsigned      kind;
    int unsigned      total;
    int unsigned      spread;
    logic [DEG_W-1:0] base;
    logic [DEG_W-1:0] deg;
    logic [VID_W-1:0] vid;
    logic [IDX_W-1:0] idx;
    while (beats_sent < TARGET_BEATS) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) n = $urandom_range(1, 10);
      else if (kind < 93) n = $urandom_range(11, 40);
      else if (kind < 97) n = $urandom_range(55, 70);  // can run into a full store
      else n = 0;                                      // draw with nothing stored
      base   = DEG_W'($urandom_range(0, 65535));
      spread = $urandom_range(0, GAP_LEVELS + 1);
      vid    = $urandom;
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) deg = DEG_W'($urandom_range(0, 65535));
        else if (base >= spread) deg = base - DEG_W'($urandom_range(0, spread));
        else deg = base;
        // now and then the same vertex comes again
        if ($urandom_range(0, 7) != 0) vid = $urandom;
        load_candidate(vid, deg);
      end
      total = stored_weight();
      kind  = $urandom_range(0, 99);
      if (total > 0 && kind < 85) idx = IDX_W'($urandom_range(0, total - 1));
      else if (total <= 1023 && kind < 95) idx = IDX_W'($urandom_range(total, 1023));
      else idx = IDX_W'($urandom_range(0, 1023));
      draw_pick(idx);
    end
  endtask

  // output side: random stall before each beat
  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 47) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, MAX_PAUSE);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compares each output beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    pick_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_picks.size() == 0) begin
        report_mismatch("beat with nothing pending", chosen_vertex_o, '0);
      end else begin
        want = pending_picks.pop_front();
        if (chosen_vertex_o !== want.vertex)
          report_mismatch("chosen_vertex", chosen_vertex_o, want.vertex);
        if (total_weight_o !== want.total)
          report_mismatch("total_weight", 32'(total_weight_o), 32'(want.total));
        if (error_o !== want.err)
          report_mismatch("error", 32'(error_o), 32'(want.err));
      end
    end
  end

  // ends a hung run: counts cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_LOAD;
    vertex_id_i    = '0;
    degree_i       = '0;
    random_index_i = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_draw();
    test_degree_extremes();
    test_index_bounds();
    test_full_store();
    test_random_sequences();

    in_valid_i <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
